/* src/pss_pkg.sv */
// shared types, constants and state encoding for the pair sum search block
package pss_pkg;

   // fixed field widths
   localparam int PRICE_W   = 14;
   localparam int TARGET_W  = 15;
   localparam int POS_OUT_W = 11;

   // parameter defaults
   localparam int VALUE_RANGE_DEF = 16384;
   localparam int MAX_ITEMS_DEF   = 1024;

   // controller states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_RDV,
      ST_RDT,
      ST_CHK,
      ST_RSP,
      ST_CLR,
      ST_TAIL
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic init_wr;
      logic idx_zero;
      logic idx_inc;
      logic cand_cap;
      logic res_clr;
      logic res_set;
      logic clr_rd;
      logic count_zero;
   } ctl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic init_last;
      logic idx_last;
      logic match;
   } dp_sts_type;

endpackage

/* src/pss_ram.sv */
// generic simple dual port ram with registered read
module pss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/pss_datapath.sv */
// datapath: value store, position table, counters, complement check and result registers
module pss_datapath import pss_pkg::*; #(
   parameter int VALUE_RANGE = VALUE_RANGE_DEF,
   parameter int MAX_ITEMS   = MAX_ITEMS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_cmd_type          cmd,
   output dp_sts_type           sts,
   input  logic [PRICE_W-1:0]   req_price,
   input  logic                 csr_wr_en,
   input  logic [TARGET_W-1:0]  csr_wr_data,
   output logic                 rsp_found,
   output logic [POS_OUT_W-1:0] rsp_first_pos,
   output logic [POS_OUT_W-1:0] rsp_second_pos
);

   localparam int VAL_AW = $clog2(VALUE_RANGE);
   localparam int POS_W  = $clog2(MAX_ITEMS);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int TAB_W  = POS_W + 1;

   logic [TARGET_W-1:0]  target_ff, target_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [POS_W-1:0]     idx_ff, idx_in;
   logic [VAL_AW-1:0]    init_addr_ff, init_addr_in;
   logic                 wipe_ff, wipe_in;
   logic                 cand_ok_ff, cand_ok_in;
   logic                 found_ff, found_in;
   logic [POS_OUT_W-1:0] p1_ff, p1_in;
   logic [POS_OUT_W-1:0] p2_ff, p2_in;

   logic                 store_room;
   logic [31:0]          price_wide;
   logic [31:0]          val_wide;
   logic [31:0]          comp_wide;
   logic [TARGET_W-1:0]  comp;
   logic                 price_in_range;
   logic                 val_in_range;
   logic [31:0]          p1_wide;
   logic [31:0]          p2_wide;

   logic                 val_we;
   logic [PRICE_W-1:0]   val_rdata;
   logic                 tab_we;
   logic [VAL_AW-1:0]    tab_waddr;
   logic [TAB_W-1:0]     tab_wdata;
   logic [TAB_W-1:0]     tab_rdata;

   // range checks and complement
   assign store_room     = count_ff < CNT_W'(MAX_ITEMS);
   assign price_wide     = 32'(req_price);
   assign val_wide       = 32'(val_rdata);
   assign price_in_range = price_wide < 32'(VALUE_RANGE);
   assign val_in_range   = val_wide < 32'(VALUE_RANGE);
   assign comp           = target_ff - TARGET_W'(val_rdata);
   assign comp_wide      = 32'(comp);
   assign p1_wide        = 32'(idx_ff) + 32'd1;
   assign p2_wide        = 32'(tab_rdata[POS_W-1:0]) + 32'd1;

   // status to controller
   assign sts.init_last = init_addr_ff == VAL_AW'(VALUE_RANGE - 1);
   assign sts.idx_last  = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign sts.match     = cand_ok_ff && tab_rdata[POS_W] &&
                          (tab_rdata[POS_W-1:0] != idx_ff);

   // value store: written on load, read at the scan / clear index
   assign val_we = cmd.load && store_room;

   pss_ram #(
      .WIDTH (PRICE_W),
      .DEPTH (MAX_ITEMS)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (count_ff[POS_W-1:0]),
      .wr_data (req_price),
      .rd_addr (idx_ff),
      .rd_data (val_rdata)
   );

   // position table write select: init sweep, per-set wipe, load
   always_comb begin
      tab_we    = 1'b0;
      tab_waddr = init_addr_ff;
      tab_wdata = '0;
      if (cmd.init_wr) begin
         tab_we = 1'b1;
      end else if (wipe_ff && val_in_range) begin
         tab_we    = 1'b1;
         tab_waddr = val_wide[VAL_AW-1:0];
      end else if (cmd.load && store_room && price_in_range) begin
         tab_we    = 1'b1;
         tab_waddr = price_wide[VAL_AW-1:0];
         tab_wdata = {1'b1, count_ff[POS_W-1:0]};
      end
   end

   // position table: valid bit and latest position per value
   pss_ram #(
      .WIDTH (TAB_W),
      .DEPTH (VALUE_RANGE)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_addr (comp_wide[VAL_AW-1:0]),
      .rd_data (tab_rdata)
   );

   // next values of counters and flags
   always_comb begin
      target_in    = csr_wr_en ? csr_wr_data : target_ff;
      count_in     = count_ff;
      if (cmd.count_zero) begin
         count_in = '0;
      end else if (val_we) begin
         count_in = count_ff + CNT_W'(1);
      end
      idx_in = idx_ff;
      if (cmd.idx_zero) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + POS_W'(1);
      end
      init_addr_in = cmd.init_wr ? init_addr_ff + VAL_AW'(1) : init_addr_ff;
      wipe_in      = cmd.clr_rd;
      cand_ok_in   = cand_ok_ff;
      if (cmd.cand_cap) begin
         cand_ok_in = (TARGET_W'(val_rdata) <= target_ff) &&
                      (comp_wide < 32'(VALUE_RANGE));
      end
   end

   // next values of result registers
   always_comb begin
      found_in = found_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      if (cmd.res_clr) begin
         found_in = 1'b0;
         p1_in    = '0;
         p2_in    = '0;
      end else if (cmd.res_set) begin
         found_in = 1'b1;
         p1_in    = p1_wide[POS_OUT_W-1:0];
         p2_in    = p2_wide[POS_OUT_W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         init_addr_ff <= '0;
         wipe_ff      <= 1'b0;
      end else begin
         target_ff    <= target_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         init_addr_ff <= init_addr_in;
         wipe_ff      <= wipe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cand_ok_ff <= cand_ok_in;
      found_ff   <= found_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
   end

   assign rsp_found      = found_ff;
   assign rsp_first_pos  = p1_ff;
   assign rsp_second_pos = p2_ff;

`ifndef SYNTHESIS
   // a wipe write never competes with a load transaction
   a_no_wipe_on_load: assert property (@(posedge clock) disable iff (reset)
      !(wipe_ff && cmd.load))
      else $error("table wipe collides with load");

   // a match is held in the result registers
   a_match_held: assert property (@(posedge clock) disable iff (reset)
      cmd.res_set |=> (found_ff && (p1_ff != '0 || POS_W >= POS_OUT_W)))
      else $error("match not captured");
`endif

endmodule

/* src/pss_controller.sv */
// controller: sequences init sweep, load, scan, result and table wipe
module pss_controller import pss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        req_last,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd,
   output logic        busy,
   output logic        rsp_valid
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (sts.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start && req_last) state_in = ST_RDV;
         end
         ST_RDV:  state_in = ST_RDT;
         ST_RDT:  state_in = ST_CHK;
         ST_CHK: begin
            if (sts.match || sts.idx_last) begin
               state_in = ST_RSP;
            end else begin
               state_in = ST_RDV;
            end
         end
         ST_RSP:  state_in = ST_CLR;
         ST_CLR: begin
            if (sts.idx_last) state_in = ST_TAIL;
         end
         ST_TAIL: state_in = ST_IDLE;
         default: state_in = ST_INIT;
      endcase
   end

   // outputs and datapath commands
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.init_wr = 1'b1;
         end
         ST_IDLE: begin
            busy         = 1'b0;
            cmd.load     = start;
            cmd.idx_zero = 1'b1;
            cmd.res_clr  = 1'b1;
         end
         ST_RDV: begin
         end
         ST_RDT: begin
            cmd.cand_cap = 1'b1;
         end
         ST_CHK: begin
            if (sts.match) begin
               cmd.res_set = 1'b1;
            end else if (!sts.idx_last) begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_RSP: begin
            rsp_valid    = 1'b1;
            cmd.idx_zero = 1'b1;
         end
         ST_CLR: begin
            cmd.clr_rd = 1'b1;
            if (!sts.idx_last) cmd.idx_inc = 1'b1;
         end
         ST_TAIL: begin
            cmd.count_zero = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // a result comes only straight out of a table check
   a_rsp_after_chk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RSP) |-> ($past(state_ff) == ST_CHK))
      else $error("result without table check");

   // the table wipe follows every result
   a_wipe_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (busy && cmd.clr_rd))
      else $error("no wipe after result");
`endif

endmodule

/* src/pair_sum_search.sv */
// top level of the pair sum search block
//
// Values of a set are taken one per cycle while busy is low (start high), and
// are written straight into the value store and the value-indexed position
// table. The transaction with req_last high closes the set: busy then stays
// high while the stored values are scanned from the first, each position
// examined in turn (value store read, table read, compare), up to the first
// match or the end of the set. The result is shown for exactly one cycle with
// rsp_valid and cannot be stalled by the receiver; no result is given for
// other transactions. After the result the table entries of the set are wiped,
// one stored value per cycle, before busy goes low. After reset the whole
// position table is cleared, one entry per cycle, while busy stays high; csr
// writes are taken at any time.
module pair_sum_search import pss_pkg::*; #(
   parameter int VALUE_RANGE = VALUE_RANGE_DEF,
   parameter int MAX_ITEMS   = MAX_ITEMS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [PRICE_W-1:0]   req_price,
   input  logic                 req_last,
   output logic                 rsp_valid,
   output logic                 rsp_found,
   output logic [POS_OUT_W-1:0] rsp_first_pos,
   output logic [POS_OUT_W-1:0] rsp_second_pos,
   input  logic                 csr_wr_en,
   input  logic [TARGET_W-1:0]  csr_wr_data
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // sequencing
   pss_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_last  (req_last),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // storage and compare
   pss_datapath #(
      .VALUE_RANGE (VALUE_RANGE),
      .MAX_ITEMS   (MAX_ITEMS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_price      (req_price),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_found      (rsp_found),
      .rsp_first_pos  (rsp_first_pos),
      .rsp_second_pos (rsp_second_pos)
   );

endmodule
